// ===== sv/fdx_pkg.sv =====
package fdx_pkg;

  localparam int MaxPayload    = 32;
  localparam int PayIdxW       = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int LenW          = $clog2(MaxPayload + 1);
  localparam int RamAddrW      = PayIdxW + 1;
  localparam int RamDepth      = 2 ** RamAddrW;
  localparam int ByteW         = 8;
  localparam int CountW        = 9;
  localparam int OutLenW       = 6;
  localparam int HeaderLen     = 3;
  localparam int FrameOverhead = 5;
  localparam int CountSat      = 256;

  typedef logic [ByteW-1:0] byte_t;

  typedef enum logic {
    CfgStartMarker = 1'b0,
    CfgEndMarker   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BackIdle,
    BackFirst,
    BackSend
  } back_state_e;

  // frame verdict handed from intake to the run generator
  typedef struct packed {
    logic            ok;
    byte_t           cmd;
    logic [LenW-1:0] len;
    logic            bank;
  } desc_t;

  typedef struct packed {
    logic                re;
    logic [RamAddrW-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic                we;
    logic [RamAddrW-1:0] addr;
    byte_t               data;
  } ram_wr_t;

  typedef struct packed {
    logic               frame_ok;
    byte_t              command;
    logic [OutLenW-1:0] payload_length;
    byte_t              payload_byte;
    logic               has_payload_byte;
    logic               run_last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== sv/fdx_ram.sv =====
module fdx_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fdx_front.sv =====
module fdx_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fdx_pkg::byte_t       data_byte_i,
  input  logic                 frame_end_i,
  input  fdx_pkg::byte_t       start_marker_i,
  input  fdx_pkg::byte_t       end_marker_i,
  input  fdx_pkg::queue_stat_t queue_stat_i,
  output logic                 push_o,
  output fdx_pkg::desc_t       desc_o,
  output fdx_pkg::ram_wr_t     ram_wr_o
);

  localparam int CountW  = fdx_pkg::CountW;
  localparam int PayIdxW = fdx_pkg::PayIdxW;
  localparam int LenW    = fdx_pkg::LenW;

  logic [CountW-1:0] count_q, count_d;
  logic              start_good_q, start_good_d;
  fdx_pkg::byte_t    cmd_q, cmd_d;
  fdx_pkg::byte_t    len_q, len_d;
  fdx_pkg::byte_t    xor_q, xor_d;
  fdx_pkg::byte_t    prev_q, prev_d;
  logic              bank_q, bank_d;

  logic              accept;
  logic [CountW-1:0] pay_off;
  logic [CountW-1:0] total;
  logic              frame_good;

  assign in_ready_o = !queue_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign pay_off    = count_q - CountW'(fdx_pkg::HeaderLen);
  assign total      = count_q + CountW'(1);

  always_comb begin
    frame_good = 1'b1;
    if (count_q >= CountW'(fdx_pkg::CountSat - 1)) frame_good = 1'b0;
    if (total < CountW'(fdx_pkg::FrameOverhead)) frame_good = 1'b0;
    if (!start_good_q) frame_good = 1'b0;
    if (total != ({1'b0, len_q} + CountW'(fdx_pkg::FrameOverhead))) frame_good = 1'b0;
    if (len_q > fdx_pkg::ByteW'(fdx_pkg::MaxPayload)) frame_good = 1'b0;
    if (data_byte_i != end_marker_i) frame_good = 1'b0;
    if (prev_q != xor_q) frame_good = 1'b0;
  end

  always_comb begin
    count_d       = count_q;
    start_good_d  = start_good_q;
    cmd_d         = cmd_q;
    len_d         = len_q;
    xor_d         = xor_q;
    prev_d        = prev_q;
    bank_d        = bank_q;
    push_o        = 1'b0;
    desc_o.ok     = frame_good;
    desc_o.cmd    = cmd_q;
    desc_o.len    = len_q[LenW-1:0];
    desc_o.bank   = bank_q;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = {bank_q, pay_off[PayIdxW-1:0]};
    ram_wr_o.data = data_byte_i;
    if (accept) begin
      if (frame_end_i) begin
        push_o       = 1'b1;
        count_d      = '0;
        start_good_d = 1'b0;
        cmd_d        = '0;
        len_d        = '0;
        xor_d        = '0;
        prev_d       = '0;
        bank_d       = !bank_q;
      end else if (!count_q[CountW-1]) begin
        if (count_q >= CountW'(2)) xor_d = xor_q ^ prev_q;
        if (count_q == '0) begin
          start_good_d = (data_byte_i == start_marker_i);
        end else if (count_q == CountW'(1)) begin
          cmd_d = data_byte_i;
        end else if (count_q == CountW'(2)) begin
          len_d = data_byte_i;
        end else if (pay_off < CountW'(fdx_pkg::MaxPayload)) begin
          ram_wr_o.we = 1'b1;
        end
        prev_d  = data_byte_i;
        count_d = count_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      start_good_q <= 1'b0;
      cmd_q        <= '0;
      len_q        <= '0;
      xor_q        <= '0;
      prev_q       <= '0;
      bank_q       <= 1'b0;
    end else begin
      count_q      <= count_d;
      start_good_q <= start_good_d;
      cmd_q        <= cmd_d;
      len_q        <= len_d;
      xor_q        <= xor_d;
      prev_q       <= prev_d;
      bank_q       <= bank_d;
    end
  end

endmodule

// ===== sv/fdx_queue.sv =====
module fdx_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fdx_pkg::desc_t       desc_i,
  input  logic                 pop_i,
  output fdx_pkg::desc_t       head_o,
  output fdx_pkg::queue_stat_t stat_o
);

  fdx_pkg::desc_t ent_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o       = ent_q[rd_ptr_q];
  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== sv/fdx_back.sv =====
module fdx_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fdx_pkg::desc_t       head_i,
  input  fdx_pkg::queue_stat_t queue_stat_i,
  output logic                 pop_o,
  output fdx_pkg::ram_rd_t     ram_rd_o,
  input  fdx_pkg::byte_t       ram_rdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fdx_pkg::result_t     out_o
);

  localparam int PayIdxW = fdx_pkg::PayIdxW;
  localparam int LenW    = fdx_pkg::LenW;
  localparam int OutLenW = fdx_pkg::OutLenW;

  fdx_pkg::back_state_e state_q, state_d;
  logic [PayIdxW-1:0]   idx_q, idx_d;
  fdx_pkg::result_t     out_q, out_d;

  function automatic fdx_pkg::result_t pay_result(fdx_pkg::desc_t d,
                                                  logic [PayIdxW-1:0] i,
                                                  fdx_pkg::byte_t data);
    fdx_pkg::result_t r;
    r.frame_ok         = 1'b1;
    r.command          = d.cmd;
    r.payload_length   = OutLenW'(d.len);
    r.payload_byte     = data;
    r.has_payload_byte = 1'b1;
    r.run_last         = ((LenW'(i) + LenW'(1)) == d.len);
    return r;
  endfunction

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    out_d         = out_q;
    pop_o         = 1'b0;
    ram_rd_o.re   = 1'b0;
    ram_rd_o.addr = {head_i.bank, idx_q + PayIdxW'(1)};
    unique case (state_q)
      fdx_pkg::BackIdle: begin
        if (!queue_stat_i.empty) begin
          if (!head_i.ok || head_i.len == '0) begin
            out_d                = '0;
            out_d.frame_ok       = head_i.ok;
            out_d.command        = head_i.ok ? head_i.cmd : '0;
            out_d.run_last       = 1'b1;
            state_d              = fdx_pkg::BackSend;
          end else begin
            ram_rd_o.re   = 1'b1;
            ram_rd_o.addr = {head_i.bank, {PayIdxW{1'b0}}};
            idx_d         = '0;
            state_d       = fdx_pkg::BackFirst;
          end
        end
      end
      fdx_pkg::BackFirst: begin
        out_d       = pay_result(head_i, idx_q, ram_rdata_i);
        ram_rd_o.re = 1'b1;
        state_d     = fdx_pkg::BackSend;
      end
      fdx_pkg::BackSend: begin
        if (out_ready_i) begin
          if (out_q.run_last) begin
            pop_o   = 1'b1;
            state_d = fdx_pkg::BackIdle;
          end else begin
            idx_d         = idx_q + PayIdxW'(1);
            out_d         = pay_result(head_i, idx_q + PayIdxW'(1), ram_rdata_i);
            ram_rd_o.re   = 1'b1;
            ram_rd_o.addr = {head_i.bank, idx_q + PayIdxW'(2)};
          end
        end
      end
      default: state_d = fdx_pkg::BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdx_pkg::BackIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    out_q <= out_d;
  end

  assign out_valid_o = (state_q == fdx_pkg::BackSend);
  assign out_o       = out_q;

endmodule

// ===== sv/frame_deframer_xor_check.sv =====
// Frame parser with XOR check byte.
// Slave stream: one raw frame byte per transfer in tdata, tlast on the final
// byte of the frame. Master stream: the answer to each frame as a run of
// transfers, tlast on the final one: one rejection transfer (frame_ok 0), one
// transfer for an empty payload, or one transfer per payload byte.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 start marker, 1 end marker); write only while the block is idle.
// Intake takes one byte per cycle while the verdict queue is not full and
// writes the payload into one half of a two-bank store; a two-entry verdict
// queue feeds the run generator, which reads the other bank. After the final
// byte's transfer the verdict enters the queue; with the output side idle the
// run generator goes straight to its send state for a rejection or empty
// payload and through a first store read otherwise; then one result per cycle
// while the receiver takes them, so a run of L bytes overlaps the next frame.
// The slave side stalls only while two frames await or run on the output,
// i.e. when both store banks are in use.
// Reset: markers return to 0xAA and 0x55, frame state and queue clear; store
// contents are undefined; unwritten bytes may be fetched ahead but are never sent.
// Receiver stall: the output transfer holds, the queue fills, then tready
// on the slave side drops until the current run drains.
module frame_deframer_xor_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [7:0] command, [13:8] payload_length, [21:14] payload_byte
  output logic [1:0]  m_axis_tuser,  // [0] frame_ok, [1] has_payload_byte
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  fdx_pkg::byte_t       start_marker_q, end_marker_q;
  fdx_pkg::queue_stat_t queue_stat;
  fdx_pkg::desc_t       push_desc, head_desc;
  logic                 push, pop;
  fdx_pkg::ram_wr_t     ram_wr;
  fdx_pkg::ram_rd_t     ram_rd;
  fdx_pkg::byte_t       ram_rdata;
  fdx_pkg::result_t     result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= 8'hAA;
      end_marker_q   <= 8'h55;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fdx_pkg::CfgStartMarker: start_marker_q <= cfg_wdata_i;
        fdx_pkg::CfgEndMarker:   end_marker_q   <= cfg_wdata_i;
        default:                 start_marker_q <= start_marker_q;
      endcase
    end
  end

  fdx_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata),
    .frame_end_i    (s_axis_tlast),
    .start_marker_i (start_marker_q),
    .end_marker_i   (end_marker_q),
    .queue_stat_i   (queue_stat),
    .push_o         (push),
    .desc_o         (push_desc),
    .ram_wr_o       (ram_wr)
  );

  fdx_ram #(
    .Width (fdx_pkg::ByteW),
    .Depth (fdx_pkg::RamDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_rd.re),
    .raddr_i (ram_rd.addr),
    .rdata_o (ram_rdata)
  );

  fdx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .pop_i  (pop),
    .head_o (head_desc),
    .stat_o (queue_stat)
  );

  fdx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_desc),
    .queue_stat_i (queue_stat),
    .pop_o        (pop),
    .ram_rd_o     (ram_rd),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  assign m_axis_tdata = {2'b00, result.payload_byte, result.payload_length, result.command};
  assign m_axis_tuser = {result.has_payload_byte, result.frame_ok};
  assign m_axis_tlast = result.run_last;

endmodule
